@@ rtl/spatial_filter_channel_mixer_core_defines.svh @@
// Assertion macros for the spatial filter channel mixer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SPATIAL_FILTER_CHANNEL_MIXER_CORE_DEFINES_SVH
`define SPATIAL_FILTER_CHANNEL_MIXER_CORE_DEFINES_SVH
`ifndef SYNTH
`define SFCM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spatial filter check failed");
`define SFCM_ASSERT_NEVER(label, expr) \
    `SFCM_ASSERT(label, !(expr))
`else
`define SFCM_ASSERT(label, prop)
`define SFCM_ASSERT_NEVER(label, expr)
`endif
`endif

@@ rtl/sfcm_pkg.sv @@
// Shared types and constants for the spatial filter channel mixer.
// Used by the core, multiplier and accumulator modules; depends on nothing.
package sfcm_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int SUM_W     = 40;
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 12;
    localparam int CH_IDX_W  = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;

    // digit-serial multiplier geometry
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    // sizing defaults and limits
    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_OUTPUTS = 16;
    localparam int RESULT_LIMIT    = 16;
    localparam int COUNT_MAX       = (1 << COUNT_W) - 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                       operation;
        logic [CH_IDX_W-1:0]        row_index;
        logic [CH_IDX_W-1:0]        channel_index;
        logic signed [COEF_W-1:0]   coefficient;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CH_IDX_W-1:0]       output_channel;
        logic signed [VALUE_W-1:0] filtered_value;
        logic                      last_of_sample;
        logic                      bad_channel;
    } out_item_t;

    typedef struct packed {
        logic term_valid;
        logic last_digit;
    } mac_status_t;

    typedef struct packed {
        logic add_en;
        logic clear_all;
    } acc_ctrl_t;

endpackage

@@ rtl/spatial_filter_channel_mixer_core.sv @@
// Coefficient load: written straight into the table. Sample beat (OC = output count): one
// 4-bit-digit multiply pass plus a table fetch per output channel,
// all through a single shared digit-serial multiplier; the last channel of a sample
// time then emits OC result beats, one per cycle without back pressure.
// Bad channel index: one result beat, through the error state and the output register.
// Reset (async, active low) zeroes accumulators and sets both counts to 16.
`include "spatial_filter_channel_mixer_core_defines.svh"
module spatial_filter_channel_mixer_core #(
    parameter int MAX_INPUTS  = sfcm_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = sfcm_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sfcm_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sfcm_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfcm_pkg::COUNT_W-1:0]      cfg_data
);
    import sfcm_pkg::*;

    localparam int TAB_DEPTH = MAX_OUTPUTS * MAX_INPUTS;
    localparam int ADDR_W    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int ACC_IDX_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int JW        = (ACC_IDX_W > COUNT_W) ? ACC_IDX_W : COUNT_W;
    localparam int IN_CAP    = (MAX_INPUTS < COUNT_MAX) ? MAX_INPUTS : COUNT_MAX;
    localparam int OUT_LIM   = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;
    localparam int OUT_CAP   = (OUT_LIM < COUNT_MAX) ? OUT_LIM : COUNT_MAX;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_LATCH, S_MUL, S_EMIT, S_ERR} state_t;

    state_t                  state_reg, state_next;
    logic [JW-1:0]           j_reg, j_next;
    logic [CH_IDX_W-1:0]     ch_reg, ch_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                    frame_end_reg, frame_end_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;
    logic [COUNT_W-1:0]      in_count_reg, in_count_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    logic [COUNT_W-1:0]      ic_eff, oc_eff;
    logic                    in_accept, slot_free, load_in_range, in_bad, in_last;
    logic                    j_is_last;
    logic [JW-1:0]           j_plus;
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [COEF_W-1:0]       ram_rdata;
    logic                    mac_load;
    logic signed [SUM_W-1:0] mac_term;
    mac_status_t             mac_status;
    acc_ctrl_t               acc_ctrl;
    logic signed [VALUE_W-1:0] acc_value;

    // table address of coefficient (row, column)
    function automatic logic [ADDR_W-1:0] tab_addr(input logic [JW-1:0] row,
                                                   input logic [CH_IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_INPUTS + int'(col));
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INPUT_COUNT:  in_count_next  = cfg_data;
                REG_OUTPUT_COUNT: out_count_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= COUNT_RESET;
            out_count_reg <= COUNT_RESET;
        end
        else
        begin
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
        end
    end

    // effective counts: zero acts as one, clipped to the sizing limits
    assign ic_eff = (in_count_reg == '0) ? COUNT_W'(1) :
                    (in_count_reg > COUNT_W'(IN_CAP)) ? COUNT_W'(IN_CAP) : in_count_reg;
    assign oc_eff = (out_count_reg == '0) ? COUNT_W'(1) :
                    (out_count_reg > COUNT_W'(OUT_CAP)) ? COUNT_W'(OUT_CAP) : out_count_reg;

    // handshake and decode
    assign in_stall      = (state_reg != S_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign slot_free     = !out_valid_reg || !out_stall;
    assign load_in_range = (int'(in_data.row_index) < MAX_OUTPUTS) &&
                           (int'(in_data.channel_index) < MAX_INPUTS);
    assign in_bad        = COUNT_W'(in_data.channel_index) >= ic_eff;
    assign in_last       = COUNT_W'(in_data.channel_index) == (ic_eff - COUNT_W'(1));
    assign j_is_last     = j_reg == (JW'(oc_eff) - JW'(1));
    assign j_plus        = j_reg + JW'(1);
    assign ram_waddr     = tab_addr(JW'(in_data.row_index), in_data.channel_index);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        ch_next        = ch_reg;
        smp_next       = smp_reg;
        frame_end_next = frame_end_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = tab_addr(j_reg, ch_reg);
        mac_load       = 1'b0;
        acc_ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.operation == OP_LOAD)
                    begin
                        ram_we = load_in_range;
                    end
                    else if (in_bad)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        ch_next        = in_data.channel_index;
                        smp_next       = in_data.sample;
                        frame_end_next = in_last;
                        j_next         = '0;
                        state_next     = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                mac_load   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_ctrl.add_en = mac_status.term_valid;
                if (mac_status.last_digit)
                begin
                    if (j_is_last)
                    begin
                        j_next     = '0;
                        state_next = frame_end_reg ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        // fetch next row's weight under the last digit
                        ram_re     = 1'b1;
                        ram_raddr  = tab_addr(j_plus, ch_reg);
                        j_next     = j_plus;
                        state_next = S_LATCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.output_channel  = j_reg[CH_IDX_W-1:0];
                    out_data_next.filtered_value  = acc_value;
                    out_data_next.last_of_sample  = j_is_last;
                    out_data_next.bad_channel     = 1'b0;
                    if (j_is_last)
                    begin
                        acc_ctrl.clear_all = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        j_next = j_plus;
                    end
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = '0;
                    out_data_next.bad_channel = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            ch_reg        <= '0;
            smp_reg       <= '0;
            frame_end_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            ch_reg        <= ch_next;
            smp_reg       <= smp_next;
            frame_end_reg <= frame_end_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // coefficient table
    sfcm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TAB_DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (in_data.coefficient),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared digit-serial multiplier
    sfcm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mac_load),
        .weight (signed'(ram_rdata)),
        .sample (smp_reg),
        .term   (mac_term),
        .status (mac_status)
    );

    // output accumulators
    sfcm_acc_bank #(
        .N (MAX_OUTPUTS)
    ) u_acc_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .idx   (j_reg[ACC_IDX_W-1:0]),
        .term  (mac_term),
        .value (acc_value)
    );

    // checks
    `SFCM_ASSERT(a_term_only_in_mul, mac_status.term_valid |-> state_reg == S_MUL)
    `SFCM_ASSERT(a_result_from_emit,
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EMIT || $past(state_reg) == S_ERR))
    `SFCM_ASSERT(a_cleared_after_frame,
        (state_reg == S_EMIT && slot_free && j_is_last) |=> acc_value == '0)
    `SFCM_ASSERT_NEVER(a_error_not_last,
        out_valid_reg && out_data_reg.bad_channel && out_data_reg.last_of_sample)

endmodule

@@ rtl/sfcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the coefficient table.
module sfcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sfcm_mac.sv @@
// Digit-serial multiplier: sample consumed 4 bits per cycle, weight shifted up.
// Emits one 40-bit partial term per cycle while busy; uses sfcm_pkg.
module sfcm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [sfcm_pkg::COEF_W-1:0]  weight,
    input  logic signed [sfcm_pkg::SAMPLE_W-1:0] sample,
    output logic signed [sfcm_pkg::SUM_W-1:0]   term,
    output sfcm_pkg::mac_status_t               status
);
    import sfcm_pkg::*;

    logic signed [SUM_W-1:0]       w_shift_reg, w_shift_next;
    logic [SAMPLE_W-1:0]           smp_shift_reg, smp_shift_next;
    logic [DIG_CNT_W-1:0]          dig_cnt_reg, dig_cnt_next;
    logic                          busy_reg, busy_next;
    logic                          is_top;
    logic signed [DIGIT_W:0]       digit_s;
    logic signed [SUM_W+DIGIT_W:0] prod;

    // top digit carries the sample sign, lower digits are unsigned
    assign is_top  = (dig_cnt_reg == DIG_CNT_W'(DIGITS - 1));
    assign digit_s = {is_top & smp_shift_reg[DIGIT_W-1], smp_shift_reg[DIGIT_W-1:0]};
    assign prod    = w_shift_reg * digit_s;
    assign term    = prod[SUM_W-1:0];

    assign status.term_valid = busy_reg;
    assign status.last_digit = busy_reg & is_top;

    // shift registers advance one digit per cycle while busy
    always_comb
    begin
        w_shift_next   = w_shift_reg;
        smp_shift_next = smp_shift_reg;
        dig_cnt_next   = dig_cnt_reg;
        busy_next      = busy_reg;
        if (load)
        begin
            w_shift_next   = SUM_W'(weight);
            smp_shift_next = sample;
            dig_cnt_next   = '0;
            busy_next      = 1'b1;
        end
        else if (busy_reg)
        begin
            w_shift_next   = w_shift_reg <<< DIGIT_W;
            smp_shift_next = smp_shift_reg >> DIGIT_W;
            dig_cnt_next   = dig_cnt_reg + DIG_CNT_W'(1);
            busy_next      = !is_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_shift_reg   <= '0;
            smp_shift_reg <= '0;
            dig_cnt_reg   <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            w_shift_reg   <= w_shift_next;
            smp_shift_reg <= smp_shift_next;
            dig_cnt_reg   <= dig_cnt_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

@@ rtl/sfcm_acc_bank.sv @@
// Output accumulators (40-bit, wrapping) and the scaling of a sum to a result.
// Uses sfcm_pkg; fed by the digit-serial multiplier.
module sfcm_acc_bank #(
    parameter int N = sfcm_pkg::DEF_MAX_OUTPUTS,
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfcm_pkg::acc_ctrl_t                 ctrl,
    input  logic [IDX_W-1:0]                    idx,
    input  logic signed [sfcm_pkg::SUM_W-1:0]   term,
    output logic signed [sfcm_pkg::VALUE_W-1:0] value
);
    import sfcm_pkg::*;

    logic signed [SUM_W-1:0]           acc_reg [N];
    logic signed [SUM_W-FRAC_BITS-1:0] scaled;

    // floor shift by 12; 28 bits always fit the 32-bit result, no clipping
    assign scaled = acc_reg[idx][SUM_W-1:FRAC_BITS];
    assign value  = VALUE_W'(scaled);

    // accumulate one partial term, or clear the whole bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.clear_all)
        begin
            for (int i = 0; i < N; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.add_en)
        begin
            acc_reg[idx] <= acc_reg[idx] + term;
        end
    end

endmodule

@@ tb/tb_spatial_filter_channel_mixer_core.sv @@
// Self-checking testbench for spatial_filter_channel_mixer_core: random and directed beats,
// with a beat-level copy of the mixer state that predicts every result beat.
// Depends on sfcm_pkg and the core RTL only.
module tb_spatial_filter_channel_mixer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcm_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD    = 300;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;

    spatial_filter_channel_mixer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mixer state as the testbench sees it
    logic signed [COEF_W-1:0] coef_mem [16][16];
    logic [SUM_W-1:0]         acc_sum  [16];
    logic [COUNT_W-1:0]       in_cnt_reg  = COUNT_RESET;
    logic [COUNT_W-1:0]       out_cnt_reg = COUNT_RESET;

    // beats waiting to go out, and output channels waiting to come back
    in_item_t  beat_q [$];
    out_item_t mixed_q [$];

    // coefficient entries already queued for loading
    bit        loaded [16][16];

    int        beats_made   = 0;
    int        beats_taken  = 0;
    int        results_seen = 0;
    int        sample_times = 0;
    int        bad_cnt      = 0;
    int        mismatches   = 0;
    int        settings     = 0;
    int        gap_left     = 0;
    int        stall_left   = 0;
    int        hold_reqs    = 0;
    int        hold_served  = 0;
    int        roll;
    bit        send_quiet   = 1'b0;
    bit        recv_quiet   = 1'b0;
    out_item_t want;

    // clamp a count register to its usable range
    function automatic int unsigned eff_count(input logic [COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 16)
            return 16;
        return v;
    endfunction

    // apply one accepted input beat, queue the output channels it produces
    function automatic void mix_beat(input in_item_t b);
        int unsigned        ic;
        int unsigned        oc;
        int unsigned        ch;
        out_item_t          r;
        logic signed [31:0] prod;
        longint             acc_v;
        ic = eff_count(in_cnt_reg);
        oc = eff_count(out_cnt_reg);
        ch = b.channel_index;
        if (b.operation == OP_LOAD) begin
            coef_mem[b.row_index][b.channel_index] = b.coefficient;
            return;
        end
        // channel beyond the configured count: single error beat, sums untouched
        if (ch >= ic) begin
            r = '0;
            r.bad_channel = 1'b1;
            mixed_q.push_back(r);
            bad_cnt++;
            return;
        end
        for (int j = 0; j < oc; j++) begin
            prod = $signed(coef_mem[j][ch]) * $signed(b.sample);
            acc_sum[j] = acc_sum[j] + {{(SUM_W-32){prod[31]}}, prod};
        end
        if (ch != ic - 1)
            return;
        // last channel: emit every output channel, floor shift, saturate
        for (int j = 0; j < oc; j++) begin
            acc_v = longint'($signed(acc_sum[j])) >>> FRAC_BITS;
            if (acc_v > 64'sd2147483647)
                acc_v = 64'sd2147483647;
            if (acc_v < -64'sd2147483648)
                acc_v = -64'sd2147483648;
            r.output_channel = j[CH_IDX_W-1:0];
            r.filtered_value = acc_v[31:0];
            r.last_of_sample = (j == oc - 1);
            r.bad_channel    = 1'b0;
            mixed_q.push_back(r);
        end
        for (int j = 0; j < 16; j++)
            acc_sum[j] = '0;
        sample_times++;
    endfunction

    // gap before the next beat: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // 16-bit word biased toward the extremes
    function automatic logic [15:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h7FFF;
        if (r < 16)
            return 16'h8000;
        if (r < 20)
            return 16'h0000;
        if (r < 24)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic queue_load(input int row, input int ch, input logic [15:0] coef);
        in_item_t b;
        b.operation     = OP_LOAD;
        b.row_index     = 4'(row);
        b.channel_index = 4'(ch);
        b.coefficient   = coef;
        b.sample        = 16'($urandom);
        beat_q.push_back(b);
        loaded[row][ch] = 1'b1;
        beats_made++;
    endtask

    // sample beat; any coefficient it reads that was never queued gets loaded first
    task automatic queue_sample(input int ch, input logic [15:0] smp);
        in_item_t    b;
        int unsigned ic;
        int unsigned oc;
        ic = eff_count(in_cnt_reg);
        oc = eff_count(out_cnt_reg);
        if (ch < ic) begin
            for (int j = 0; j < oc; j++) begin
                if (!loaded[j][ch])
                    queue_load(j, ch, rand_word());
            end
        end
        b.operation     = OP_SAMPLE;
        b.row_index     = 4'($urandom_range(0, 15));
        b.channel_index = 4'(ch);
        b.coefficient   = 16'($urandom);
        b.sample        = smp;
        beat_q.push_back(b);
        beats_made++;
    endtask

    // random traffic: mostly complete sample times, some loads, bad and stray channels
    task automatic mix_random(input int n);
        int stop;
        int pick;
        int ic;
        stop = beats_made + n;
        ic   = eff_count(in_cnt_reg);
        while (beats_made < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int k = 0; k < ic; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        queue_load($urandom_range(0, 15), $urandom_range(0, 15), rand_word());
                    queue_sample(k, rand_word());
                end
            end else if (pick < 80) begin
                queue_load($urandom_range(0, 15), $urandom_range(0, 15), rand_word());
            end else if (pick < 88 && ic < 16) begin
                queue_sample($urandom_range(ic, 15), rand_word());
            end else begin
                queue_sample($urandom_range(0, ic - 1), rand_word());
            end
        end
    endtask

    // all beats accepted, all results back, then let any pending work finish
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beats_taken != beats_made || mixed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_INPUT_COUNT)
            in_cnt_reg = val;
        else
            out_cnt_reg = val;
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] ic_v, input logic [COUNT_W-1:0] oc_v,
                             input int n, input bit long_hold);
        wait_drained();
        write_count(REG_INPUT_COUNT, ic_v);
        write_count(REG_OUTPUT_COUNT, oc_v);
        settings++;
        if (long_hold)
            hold_reqs <= hold_reqs + 1;
        mix_random(n);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input driver: one beat at a time from beat_q
    always @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            mix_beat(in_data);
            beats_taken++;
        end
        if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                in_data  <= beat_q.pop_front();
                in_valid <= 1'b1;
                gap_left <= pick_gap(send_quiet);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back pressure, including the requested long hold
    always @(posedge clk)
    begin
        if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            stall_left  <= LONG_HOLD;
            out_stall   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (recv_quiet) begin
            out_stall <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else if (roll < 17) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 30);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // output monitor: each result beat against the oldest queued channel
    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            results_seen++;
            if (mixed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: ch %0d value %0d last %0b bad %0b",
                             out_data.output_channel, $signed(out_data.filtered_value),
                             out_data.last_of_sample, out_data.bad_channel);
            end else begin
                want = mixed_q.pop_front();
                if (out_data.output_channel !== want.output_channel
                    || out_data.filtered_value !== want.filtered_value
                    || out_data.last_of_sample !== want.last_of_sample
                    || out_data.bad_channel !== want.bad_channel) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result beat %0d: exp ch %0d value %0d last %0b bad %0b",
                                 results_seen, want.output_channel, $signed(want.filtered_value),
                                 want.last_of_sample, want.bad_channel);
                    if (mismatches <= 10)
                        $display("    got ch %0d value %0d last %0b bad %0b",
                                 out_data.output_channel, $signed(out_data.filtered_value),
                                 out_data.last_of_sample, out_data.bad_channel);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #25_000_000;
        $display("spatial_filter_channel_mixer_core test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        for (int j = 0; j < 16; j++) begin
            acc_sum[j] = '0;
            for (int k = 0; k < 16; k++) begin
                coef_mem[j][k] = '0;
                loaded[j][k]   = 1'b0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: 3 inputs, 2 outputs
        write_count(REG_INPUT_COUNT, 5'd3);
        write_count(REG_OUTPUT_COUNT, 5'd2);
        settings++;
        queue_load(0, 0, 16'h7FFF);
        queue_load(1, 0, 16'h8000);
        queue_load(0, 1, 16'h1000);
        queue_load(1, 1, 16'hFFFF);
        queue_load(0, 2, 16'h0001);
        queue_load(1, 2, 16'h0000);
        // full-scale samples through extreme weights
        queue_sample(0, 16'h7FFF);
        queue_sample(1, 16'h8000);
        queue_sample(2, 16'hFFFF);
        // channel index past the count, lowest and highest
        queue_sample(3, 16'h1234);
        queue_sample(15, 16'h7FFF);
        // repeated channel in one sample time
        queue_sample(0, 16'h0001);
        queue_sample(0, 16'hFFFF);
        queue_sample(1, 16'h5555);
        queue_sample(2, 16'hAAAA);
        // skipped channels, and a small negative sum that floors to -1
        queue_sample(2, 16'h0001);
        queue_sample(1, 16'h0001);
        queue_sample(2, 16'h0000);
        // corners of the table outside the active area
        queue_load(15, 15, 16'h5A5A);
        queue_load(15, 0, 16'hA5A5);
        queue_load(0, 15, 16'h8001);

        // one input, 31 outputs (clamped to 16); receiver holds off long
        wait_drained();
        send_quiet <= 1'b1;
        run_phase(5'd1, 5'd31, 45, 1'b1);
        wait_drained();
        send_quiet <= 1'b0;

        run_phase(5'd31, 5'd1, 60, 1'b0);

        // zero counts act as one; no idling on either side
        send_quiet <= 1'b1;
        recv_quiet <= 1'b1;
        run_phase(5'd0, 5'd0, 30, 1'b0);
        wait_drained();
        send_quiet <= 1'b0;
        recv_quiet <= 1'b0;

        run_phase(5'd5, 5'd7, 70, 1'b0);
        run_phase(5'd12, 5'd4, 60, 1'b0);
        run_phase(5'($urandom_range(1, 8)), 5'($urandom_range(1, 10)), 60, 1'b0);
        run_phase(5'd16, 5'd3, 40, 1'b0);

        wait_drained();
        $display("covered %0d input beats over %0d count settings, %0d result beats checked",
                 beats_taken, settings, results_seen);
        $display("  %0d sample times emitted, %0d bad-channel results, %0d mismatches",
                 sample_times, bad_cnt, mismatches);
        if (mismatches == 0)
            $display("spatial_filter_channel_mixer_core test passed");
        else
            $display("spatial_filter_channel_mixer_core test failed");
        $finish;
    end

endmodule
